// File: design/prsf_pkg.sv
// shared constants and types for the point region selection filter
package prsf_pkg;

  // field widths
  localparam int IDX_W = 20;
  localparam int CRD_W = 24;

  // stream and config port widths
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  // internal datapath widths
  localparam int DW   = CRD_W + 2;   // doubled offset 2p - (min+max), signed
  localparam int AW   = CRD_W + 1;   // axis span max - min, signed
  localparam int MW   = 2 * CRD_W;   // one limb product
  localparam int PW   = 3 * CRD_W;   // scaled offset, three limbs
  localparam int SQW  = 6 * CRD_W;   // square of a scaled offset
  localparam int CRW  = 4 * CRD_W + 1; // packed cross terms of a square
  localparam int SUMW = SQW + 2;     // sum of three squares

  // pipeline depth, last stage is the output register
  localparam int NSTG = 11;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_MIN = 3'd0,
    CFG_X_MAX = 3'd1,
    CFG_Y_MIN = 3'd2,
    CFG_Y_MAX = 3'd3,
    CFG_Z_MIN = 3'd4,
    CFG_Z_MAX = 3'd5,
    CFG_MODE  = 3'd6
  } cfg_idx_t;

  // per-item tag that travels with the data
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             ell_ok;  // every axis has positive span and |doubled offset| <= span
    logic             box_ok;  // min <= coord <= max on every axis
  } tag_t;

endpackage

// File: design/point_region_selection_filter_core.sv
// point region selection filter: box or inscribed ellipsoid test, deep pipeline
// 11 register stages; out_tvalid is the valid bit of the last stage
// throughput: one item per cycle while out_tready is high; a stalled output only fills bubbles behind it
// the 11-stage pipeline uses 24x24 limb multipliers
// reset (rst_n low, synchronous) empties the pipeline and clears all region
// registers to zero, box mode
module point_region_selection_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [prsf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [prsf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // point items in
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [prsf_pkg::IN_TDATA_W-1:0]     in_tdata,   // point_index, coord_x, coord_y, coord_z
  // result items out
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [prsf_pkg::OUT_TDATA_W-1:0]    out_tdata,  // result_index
  output logic                                out_tuser   // inside_res
);

  localparam int CW = prsf_pkg::CRD_W;
  localparam int NS = prsf_pkg::NSTG;

  // region registers
  logic [CW-1:0] sel_min_r [3];
  logic [CW-1:0] sel_max_r [3];
  logic          mode_r;

  // pipeline control
  logic [NS-1:0]       vld_r;
  logic [NS-1:0]       vld_in;
  logic [NS-1:0]       adv;
  prsf_pkg::tag_t      tag_r  [NS];
  prsf_pkg::tag_t      tag_in [NS];
  logic                in_acc;
  logic                out_acc;

  // stage 0: offsets, spans, box test
  logic [CW-1:0]             crd     [3];
  logic [prsf_pkg::AW-1:0]   s0_sum  [3];
  logic [2:0]                box_ax;
  logic [prsf_pkg::DW-1:0]   dx_nxt  [3];
  logic [prsf_pkg::DW-1:0]   dx_r    [3];
  logic [prsf_pkg::AW-1:0]   ax_nxt  [3];
  logic [prsf_pkg::AW-1:0]   ax_r    [3];
  // stage 1: magnitudes and range prefilter
  logic [prsf_pkg::DW-1:0]   mag     [3];
  logic [2:0]                ok_ax;
  logic [CW-1:0]             d_nxt   [3];
  logic [CW-1:0]             d_r     [3];
  logic [CW-1:0]             a_nxt   [3];
  logic [CW-1:0]             a_r     [3];
  // stage 2: pairwise span products
  logic [prsf_pkg::MW-1:0]   pa_nxt  [3];
  logic [prsf_pkg::MW-1:0]   pa_r    [3];
  logic [CW-1:0]             d2_r    [3];
  logic [CW-1:0]             ax2_r;
  // stage 3: partial products of scaled offsets and span volume
  logic [prsf_pkg::MW-1:0]   ph_nxt  [4];
  logic [prsf_pkg::MW-1:0]   pl_nxt  [4];
  logic [prsf_pkg::MW-1:0]   ph_r    [4];
  logic [prsf_pkg::MW-1:0]   pl_r    [4];
  // stage 4: scaled values
  logic [prsf_pkg::PW-1:0]   pv_nxt  [4];
  logic [prsf_pkg::PW-1:0]   pv_r    [4];
  // stage 5: limb products of each square
  logic [prsf_pkg::MW-1:0]   dg_nxt  [4][3];
  logic [prsf_pkg::MW-1:0]   cx_nxt  [4][3];
  logic [prsf_pkg::MW-1:0]   dg_r    [4][3];
  logic [prsf_pkg::MW-1:0]   cx_r    [4][3];
  // stage 6: diagonal and cross sums
  logic [prsf_pkg::SQW-1:0]  diag_nxt [4];
  logic [prsf_pkg::CRW-1:0]  cr_nxt   [4];
  logic [prsf_pkg::SQW-1:0]  diag_r   [4];
  logic [prsf_pkg::CRW-1:0]  cr_r     [4];
  // stage 7: squares
  logic [prsf_pkg::SQW-1:0]  sq_nxt   [4];
  logic [prsf_pkg::SQW-1:0]  sq_r     [4];
  // stage 8 and 9: sum of the three squares
  logic [prsf_pkg::SUMW-2:0] sxy_nxt;
  logic [prsf_pkg::SUMW-2:0] sxy_r;
  logic [prsf_pkg::SQW-1:0]  sz_r;
  logic [prsf_pkg::SQW-1:0]  sr_r;
  logic [prsf_pkg::SUMW-1:0] sall_nxt;
  logic [prsf_pkg::SUMW-1:0] sall_r;
  logic [prsf_pkg::SQW-1:0]  sr2_r;
  // stage 10: output
  logic                      inside_nxt;
  logic                      inside_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sel_min_r[i] <= '0;
        sel_max_r[i] <= '0;
      end
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (prsf_pkg::cfg_idx_t'(cfg_addr))
        prsf_pkg::CFG_X_MIN: sel_min_r[0] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_X_MAX: sel_max_r[0] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_Y_MIN: sel_min_r[1] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_Y_MAX: sel_max_r[1] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_Z_MIN: sel_min_r[2] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_Z_MAX: sel_max_r[2] <= cfg_wdata[CW-1:0];
        prsf_pkg::CFG_MODE:  mode_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // per-stage advance: a stage moves when empty or when the one after it moves
  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // stage 0 logic
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crd[i]    = in_tdata[prsf_pkg::IDX_W + CW*i +: CW];
      s0_sum[i] = {sel_min_r[i][CW-1], sel_min_r[i]} + {sel_max_r[i][CW-1], sel_max_r[i]};
      dx_nxt[i] = {crd[i][CW-1], crd[i], 1'b0} - {s0_sum[i][CW], s0_sum[i]};
      ax_nxt[i] = {sel_max_r[i][CW-1], sel_max_r[i]} - {sel_min_r[i][CW-1], sel_min_r[i]};
      box_ax[i] = ($signed(crd[i]) >= $signed(sel_min_r[i])) &&
                  ($signed(crd[i]) <= $signed(sel_max_r[i]));
    end
  end

  // stage 1 logic
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]   = dx_r[i][prsf_pkg::DW-1] ? (prsf_pkg::DW'(0) - dx_r[i]) : dx_r[i];
      ok_ax[i] = !ax_r[i][prsf_pkg::AW-1] && (ax_r[i] != '0) && (mag[i] <= {1'b0, ax_r[i]});
      d_nxt[i] = mag[i][CW-1:0];
      a_nxt[i] = ax_r[i][CW-1:0];
    end
  end

  // tags and valid bits entering each stage
  always_comb begin
    tag_in[0].idx    = in_tdata[prsf_pkg::IDX_W-1:0];
    tag_in[0].ell_ok = 1'b0;
    tag_in[0].box_ok = &box_ax;
    tag_in[1]        = tag_r[0];
    tag_in[1].ell_ok = &ok_ax;
    for (int k = 2; k < NS; k++) begin
      tag_in[k] = tag_r[k-1];
    end
    vld_in = {vld_r[NS-2:0], in_tvalid};
  end

  // stages 2 to 9 arithmetic and the stage 10 decision
  always_comb begin
    // span products: yz, xz, xy
    pa_nxt[0] = a_r[1] * a_r[2];
    pa_nxt[1] = a_r[0] * a_r[2];
    pa_nxt[2] = a_r[0] * a_r[1];
    // offsets times the other two spans, and x span times yz for the volume
    for (int j = 0; j < 3; j++) begin
      ph_nxt[j] = d2_r[j] * pa_r[j][prsf_pkg::MW-1:CW];
      pl_nxt[j] = d2_r[j] * pa_r[j][CW-1:0];
    end
    ph_nxt[3] = ax2_r * pa_r[0][prsf_pkg::MW-1:CW];
    pl_nxt[3] = ax2_r * pa_r[0][CW-1:0];
    for (int j = 0; j < 4; j++) begin
      pv_nxt[j] = {ph_r[j], {CW{1'b0}}} + prsf_pkg::PW'(pl_r[j]);
      // limb products of the square
      dg_nxt[j][0] = pv_r[j][CW-1:0]    * pv_r[j][CW-1:0];
      dg_nxt[j][1] = pv_r[j][2*CW-1:CW] * pv_r[j][2*CW-1:CW];
      dg_nxt[j][2] = pv_r[j][3*CW-1:2*CW] * pv_r[j][3*CW-1:2*CW];
      cx_nxt[j][0] = pv_r[j][CW-1:0]    * pv_r[j][2*CW-1:CW];
      cx_nxt[j][1] = pv_r[j][CW-1:0]    * pv_r[j][3*CW-1:2*CW];
      cx_nxt[j][2] = pv_r[j][2*CW-1:CW] * pv_r[j][3*CW-1:2*CW];
      // diagonals do not overlap; cross terms packed relative to one limb up
      diag_nxt[j] = {dg_r[j][2], dg_r[j][1], dg_r[j][0]};
      cr_nxt[j]   = prsf_pkg::CRW'({cx_r[j][2], cx_r[j][0]}) +
                    prsf_pkg::CRW'({cx_r[j][1], {CW{1'b0}}});
      // square = diagonals + 2 * cross terms shifted by one limb
      sq_nxt[j]   = diag_r[j] + prsf_pkg::SQW'({cr_r[j], {(CW+1){1'b0}}});
    end
    sxy_nxt  = {1'b0, sq_r[0]} + {1'b0, sq_r[1]};
    sall_nxt = {1'b0, sxy_r} + prsf_pkg::SUMW'(sz_r);
    // final decision
    inside_nxt = mode_r ? (tag_r[NS-2].ell_ok && (sall_r <= prsf_pkg::SUMW'(sr2_r)))
                        : tag_r[NS-2].box_ok;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) vld_r[k] <= vld_in[k];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) tag_r[k] <= tag_in[k];
    end
    if (adv[0]) begin
      dx_r <= dx_nxt;
      ax_r <= ax_nxt;
    end
    if (adv[1]) begin
      d_r <= d_nxt;
      a_r <= a_nxt;
    end
    if (adv[2]) begin
      pa_r  <= pa_nxt;
      d2_r  <= d_r;
      ax2_r <= a_r[0];
    end
    if (adv[3]) begin
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (adv[4]) pv_r <= pv_nxt;
    if (adv[5]) begin
      dg_r <= dg_nxt;
      cx_r <= cx_nxt;
    end
    if (adv[6]) begin
      diag_r <= diag_nxt;
      cr_r   <= cr_nxt;
    end
    if (adv[7]) sq_r <= sq_nxt;
    if (adv[8]) begin
      sxy_r <= sxy_nxt;
      sz_r  <= sq_r[2];
      sr_r  <= sq_r[3];
    end
    if (adv[9]) begin
      sall_r <= sall_nxt;
      sr2_r  <= sr_r;
    end
    if (adv[10]) inside_r <= inside_nxt;
  end

  // output port
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = prsf_pkg::OUT_TDATA_W'(tag_r[NS-1].idx);
  assign out_tuser  = inside_r;

  // items in flight change only by accepted and delivered items
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(vld_r) ==
               $past($countones(vld_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline lost or duplicated an item");

  // input is refused only when every stage holds an item
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input stalled while a bubble exists");

  // the ellipsoid prefilter passing implies the point is inside the box
  a_ell_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NS-1] && tag_r[NS-1].ell_ok) |-> tag_r[NS-1].box_ok)
    else $error("ellipsoid range check disagrees with box test");

endmodule
